// ----- hdl/qcst_pkg.sv -----
package qcst_pkg;

	// Coordinate format: signed, 4 integer bits plus the fraction
	localparam int COORD_FRAC_BITS = 16;
	localparam int COORD_W         = COORD_FRAC_BITS + 4;
	localparam int HALF_W          = COORD_FRAC_BITS + 3;
	localparam int ERR_W           = 16;
	localparam int DEPTH_W         = 5;

	// Intermediate widths, all derived from the coordinate width
	localparam int DEL_W  = COORD_W + 1;   // point minus center
	localparam int ABS_W  = DEL_W;         // magnitude of a difference
	localparam int SUM_W  = COORD_W + 2;   // two differences added
	localparam int D_W    = COORD_W + 2;   // corner distance
	localparam int R2_W   = COORD_W + 3;   // midpoint distance, doubled
	localparam int R4_W   = COORD_W + 4;   // center distance, quadrupled
	localparam int E2_W   = COORD_W + 4;   // midpoint error
	localparam int E4_W   = COORD_W + 5;   // center error
	localparam int SQ_W   = 2 * DEL_W;     // any square
	localparam int DIAG_W = SQ_W + 1;      // squared diagonal

	// Stream and register port widths
	localparam int IN_W        = 4 * COORD_W + DEPTH_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = 4;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = COORD_W;

	// Register reset values: center 0.65, half size 0.25
	localparam logic [COORD_W-1:0] CENTER_RST = COORD_W'((65 * (1 << COORD_FRAC_BITS)) / 100);
	localparam logic [HALF_W-1:0]  HALF_RST   = HALF_W'(1 << (COORD_FRAC_BITS - 2));
	localparam logic [ERR_W-1:0]   LIMIT_RST  = ERR_W'(1);
	localparam logic [DEPTH_W-1:0] DEPTH_RST  = DEPTH_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X     = 3'd0,
		CFG_CENTER_Y     = 3'd1,
		CFG_HALF_SIZE    = 3'd2,
		CFG_ERROR_LIMIT  = 3'd3,
		CFG_TARGET_DEPTH = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [HALF_W-1:0]         half_size;
		logic [ERR_W-1:0]          error_limit;
		logic [DEPTH_W-1:0]        target_depth;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] low_x;
		logic signed [COORD_W-1:0] low_y;
		logic signed [COORD_W-1:0] high_x;
		logic signed [COORD_W-1:0] high_y;
		logic [DEPTH_W-1:0]        level;
	} box_t;

	// Front-end result: magnitudes and edge squares
	typedef struct packed {
		logic [ABS_W-1:0]   ax_l;
		logic [ABS_W-1:0]   ax_h;
		logic [ABS_W-1:0]   ay_l;
		logic [ABS_W-1:0]   ay_h;
		logic [SUM_W-1:0]   sx;
		logic [SUM_W-1:0]   sy;
		logic [SQ_W-1:0]    ex2;
		logic [SQ_W-1:0]    ey2;
		logic [DEPTH_W-1:0] level;
	} delta_t;

	// Field result: squares, signs, true and interpolated distances
	typedef struct packed {
		logic [3:0][SQ_W-1:0] dsq;
		logic [3:0]           neg;
		logic [3:0][R2_W-1:0] r2;
		logic [3:0][R2_W-1:0] a2;
		logic [R4_W-1:0]      r4;
		logic [R4_W-1:0]      sum4;
		logic [DIAG_W-1:0]    diag2;
		logic [DEPTH_W-1:0]   level;
	} field_t;

	function automatic logic signed [DEL_W-1:0] ext_del(input logic signed [COORD_W-1:0] v);
		return {v[COORD_W-1], v};
	endfunction

	function automatic logic [ABS_W-1:0] abs_del(input logic signed [DEL_W-1:0] v);
		return v[DEL_W-1] ? ABS_W'(-v) : ABS_W'(v);
	endfunction

	function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
	endfunction

	function automatic logic [SUM_W-1:0] max_sum(input logic [SUM_W-1:0] a,
	                                             input logic [SUM_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ----- hdl/qcst_delta.sv -----
module qcst_delta (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qcst_pkg::box_t   box,
	input  qcst_pkg::cfg_t   cfg,
	output logic             out_valid,
	input  logic             out_ready,
	output qcst_pkg::delta_t delta
);
	import qcst_pkg::*;

	logic                     v_s1, v_s2, en_s1, en_s2;
	logic signed [DEL_W-1:0]  dx_l_s1, dx_h_s1, dy_l_s1, dy_h_s1, ex_s1, ey_s1;
	logic [DEPTH_W-1:0]       level_s1;
	delta_t                   delta_s2;
	logic signed [SUM_W-1:0]  sum_x, sum_y;
	logic signed [SQ_W-1:0]   ex_sq, ey_sq;

	// Advance a stage when it is empty or its successor advances
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// Stage 1: offsets of the corner coordinates from the center, edge lengths
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dx_l_s1  <= ext_del(box.low_x)  - ext_del(cfg.center_x);
			dx_h_s1  <= ext_del(box.high_x) - ext_del(cfg.center_x);
			dy_l_s1  <= ext_del(box.low_y)  - ext_del(cfg.center_y);
			dy_h_s1  <= ext_del(box.high_y) - ext_del(cfg.center_y);
			ex_s1    <= ext_del(box.high_x) - ext_del(box.low_x);
			ey_s1    <= ext_del(box.high_y) - ext_del(box.low_y);
			level_s1 <= box.level;
		end
	end

	// Stage 2: magnitudes, midpoint sums and squared edge lengths
	assign sum_x = SUM_W'(dx_l_s1) + SUM_W'(dx_h_s1);
	assign sum_y = SUM_W'(dy_l_s1) + SUM_W'(dy_h_s1);
	assign ex_sq = ex_s1 * ex_s1;
	assign ey_sq = ey_s1 * ey_s1;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			delta_s2.ax_l  <= abs_del(dx_l_s1);
			delta_s2.ax_h  <= abs_del(dx_h_s1);
			delta_s2.ay_l  <= abs_del(dy_l_s1);
			delta_s2.ay_h  <= abs_del(dy_h_s1);
			delta_s2.sx    <= abs_sum(sum_x);
			delta_s2.sy    <= abs_sum(sum_y);
			delta_s2.ex2   <= $unsigned(ex_sq);
			delta_s2.ey2   <= $unsigned(ey_sq);
			delta_s2.level <= level_s1;
		end
	end

	assign out_valid = v_s2;
	assign delta     = delta_s2;

	// A stalled stage keeps its item
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_ready) |=> (v_s2 && $stable(delta_s2)))
		else $error("stage 2 item changed while stalled");

endmodule

// ----- hdl/qcst_field.sv -----
module qcst_field (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qcst_pkg::delta_t delta,
	input  qcst_pkg::cfg_t   cfg,
	output logic             out_valid,
	input  logic             out_ready,
	output qcst_pkg::field_t field
);
	import qcst_pkg::*;

	logic                    v_s3, v_s4, en_s3, en_s4;
	logic [3:0][D_W-1:0]     d_c;
	logic [3:0][R2_W-1:0]    r2_c;
	logic [R4_W-1:0]         r4_c;
	logic [3:0][D_W-1:0]     d_s3;
	logic [3:0][R2_W-1:0]    r2_s3;
	logic [R4_W-1:0]         r4_s3;
	logic [DIAG_W-1:0]       diag2_s3;
	logic [DEPTH_W-1:0]      level_s3;
	logic signed [2*D_W-1:0] prod [4];
	field_t                  field_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 3: Chebyshev distances at corners (0 low/low, 1 low/high, 2 high/high,
	// 3 high/low), at the edge midpoints between neighbors and at the center
	always_comb begin
		d_c[0] = D_W'(max_sum(SUM_W'(delta.ax_l), SUM_W'(delta.ay_l))) - D_W'(cfg.half_size);
		d_c[1] = D_W'(max_sum(SUM_W'(delta.ax_l), SUM_W'(delta.ay_h))) - D_W'(cfg.half_size);
		d_c[2] = D_W'(max_sum(SUM_W'(delta.ax_h), SUM_W'(delta.ay_h))) - D_W'(cfg.half_size);
		d_c[3] = D_W'(max_sum(SUM_W'(delta.ax_h), SUM_W'(delta.ay_l))) - D_W'(cfg.half_size);
		r2_c[0] = R2_W'(max_sum({delta.ax_l, 1'b0}, delta.sy)) - R2_W'({cfg.half_size, 1'b0});
		r2_c[1] = R2_W'(max_sum(delta.sx, {delta.ay_h, 1'b0})) - R2_W'({cfg.half_size, 1'b0});
		r2_c[2] = R2_W'(max_sum({delta.ax_h, 1'b0}, delta.sy)) - R2_W'({cfg.half_size, 1'b0});
		r2_c[3] = R2_W'(max_sum(delta.sx, {delta.ay_l, 1'b0})) - R2_W'({cfg.half_size, 1'b0});
		r4_c    = R4_W'({max_sum(delta.sx, delta.sy), 1'b0}) - R4_W'({cfg.half_size, 2'b00});
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			d_s3     <= d_c;
			r2_s3    <= r2_c;
			r4_s3    <= r4_c;
			diag2_s3 <= DIAG_W'(delta.ex2) + DIAG_W'(delta.ey2);
			level_s3 <= delta.level;
		end
	end

	// Stage 4: square the corner distances, interpolate midpoints and center
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i] = $signed(d_s3[i]) * $signed(d_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int i = 0; i < 4; i++) begin
				field_s4.dsq[i] <= prod[i][SQ_W-1:0];
				field_s4.neg[i] <= d_s3[i][D_W-1] || (d_s3[i] == '0);
				field_s4.a2[i]  <= R2_W'($signed(d_s3[i])) + R2_W'($signed(d_s3[(i + 1) % 4]));
			end
			field_s4.r2    <= r2_s3;
			field_s4.r4    <= r4_s3;
			field_s4.sum4  <= R4_W'($signed(d_s3[0])) + R4_W'($signed(d_s3[1]))
			                + R4_W'($signed(d_s3[2])) + R4_W'($signed(d_s3[3]));
			field_s4.diag2 <= diag2_s3;
			field_s4.level <= level_s3;
		end
	end

	assign out_valid = v_s4;
	assign field     = field_s4;

	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !out_ready) |=> (v_s4 && $stable(field_s4)))
		else $error("stage 4 item changed while stalled");

endmodule

// ----- hdl/qcst_decide.sv -----
module qcst_decide (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qcst_pkg::field_t field,
	input  qcst_pkg::cfg_t   cfg,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             split,
	output logic             straddles,
	output logic             far_corner,
	output logic             error_high
);
	import qcst_pkg::*;

	logic                   v_s5, en_s5;
	logic                   far_c, err_c, strad_c;
	logic signed [E2_W-1:0] e2 [4];
	logic signed [E4_W-1:0] e4;
	logic [E2_W-1:0]        e2_abs [4];
	logic [E4_W-1:0]        e4_abs;
	logic                   split_s5, strad_s5, far_s5, err_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= in_valid;
		end
	end

	// Stage 5: compare squares against the diagonal and errors against the limit
	always_comb begin
		far_c = 1'b0;
		err_c = 1'b0;
		for (int i = 0; i < 4; i++) begin
			e2[i]     = E2_W'($signed(field.r2[i])) - E2_W'($signed(field.a2[i]));
			e2_abs[i] = e2[i][E2_W-1] ? E2_W'(-e2[i]) : E2_W'(e2[i]);
			if (DIAG_W'(field.dsq[i]) > field.diag2) far_c = 1'b1;
			if (e2_abs[i] > E2_W'({cfg.error_limit, 1'b0})) err_c = 1'b1;
		end
		e4     = E4_W'($signed(field.r4)) - E4_W'($signed(field.sum4));
		e4_abs = e4[E4_W-1] ? E4_W'(-e4) : E4_W'(e4);
		if (e4_abs > E4_W'({cfg.error_limit, 2'b00})) err_c = 1'b1;
		strad_c = (|field.neg) && !(&field.neg);
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			far_s5   <= far_c;
			err_s5   <= err_c;
			strad_s5 <= strad_c;
			split_s5 <= (!far_c || strad_c) && err_c && (field.level < cfg.target_depth);
		end
	end

	assign out_valid  = v_s5;
	assign split      = split_s5;
	assign straddles  = strad_s5;
	assign far_corner = far_s5;
	assign error_high = err_s5;

	a_split_cause: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (!split_s5 || (err_s5 && (!far_s5 || strad_s5))))
		else $error("split set without error and need");

endmodule

// ----- hdl/quadtree_cell_split_test_core.sv -----
// Channel | Dir | Width | Contents (lowest bit first)
// s_*     | in  | 88    | low_x[19:0] low_y[39:20] high_x[59:40] high_y[79:60] level[84:80]
// m_*     | out | 8     | split[0] straddles[1] far_corner[2] error_high[3]
// cfg_*   | in  | 3+20  | register index, write data; taken when cfg_we is high
//
// One cell enters every clock while s_tready is high; its result is loaded into the output
// register after passing five register stages (offsets, magnitudes/squares, distances,
// interpolation/squares, decision). Throughput is one cell per clock while
// m_tready does not stall the output. arst_n clears all valid bits and loads the
// register defaults. A stall on m_tready fills bubbles first, then backs up
// into s_tready; no item is lost or repeated.
module quadtree_cell_split_test_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// low_x, low_y, high_x, high_y, level, zero fill
	input  logic [qcst_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// split, straddles, far_corner, error_high, zero fill
	output logic [qcst_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [qcst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qcst_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import qcst_pkg::*;

	cfg_t   cfg_q;
	box_t   box;
	delta_t delta;
	field_t field;
	logic   delta_valid, delta_ready, field_valid, field_ready;
	logic   split, straddles, far_corner, error_high;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x     <= CENTER_RST;
			cfg_q.center_y     <= CENTER_RST;
			cfg_q.half_size    <= HALF_RST;
			cfg_q.error_limit  <= LIMIT_RST;
			cfg_q.target_depth <= DEPTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_X:     cfg_q.center_x     <= cfg_data[COORD_W-1:0];
				CFG_CENTER_Y:     cfg_q.center_y     <= cfg_data[COORD_W-1:0];
				CFG_HALF_SIZE:    cfg_q.half_size    <= cfg_data[HALF_W-1:0];
				CFG_ERROR_LIMIT:  cfg_q.error_limit  <= cfg_data[ERR_W-1:0];
				CFG_TARGET_DEPTH: cfg_q.target_depth <= cfg_data[DEPTH_W-1:0];
				default:          ;
			endcase
		end
	end

	// Unpack the input transaction
	assign box.low_x  = s_tdata[COORD_W-1:0];
	assign box.low_y  = s_tdata[2*COORD_W-1:COORD_W];
	assign box.high_x = s_tdata[3*COORD_W-1:2*COORD_W];
	assign box.high_y = s_tdata[4*COORD_W-1:3*COORD_W];
	assign box.level  = s_tdata[4*COORD_W+DEPTH_W-1:4*COORD_W];

	qcst_delta u_delta (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.box       (box),
		.cfg       (cfg_q),
		.out_valid (delta_valid),
		.out_ready (delta_ready),
		.delta     (delta)
	);

	qcst_field u_field (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (delta_valid),
		.in_ready  (delta_ready),
		.delta     (delta),
		.cfg       (cfg_q),
		.out_valid (field_valid),
		.out_ready (field_ready),
		.field     (field)
	);

	qcst_decide u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (field_valid),
		.in_ready   (field_ready),
		.field      (field),
		.cfg        (cfg_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.split      (split),
		.straddles  (straddles),
		.far_corner (far_corner),
		.error_high (error_high)
	);

	// Pack the output transaction
	assign m_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, error_high, far_corner, straddles, split};

	// Input backs up only when every stage and the output register are full
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while output not blocked");

endmodule
